FILE: rtl/ard_pkg.sv
`default_nettype none

package ard_pkg;

   // Defaults for the top-level parameters.
   localparam int DIM_BITS_DEF  = 16;
   localparam int FRAC_BITS_DEF = 16;

   // Fixed field widths of the two channels.
   localparam int SIDE_BITS    = 16;
   localparam int REDUCED_BITS = 16;
   localparam int SCALED_BITS  = 32;

   typedef struct packed {
      logic [SIDE_BITS-1:0] width;
      logic [SIDE_BITS-1:0] height;
   } req_type;

   typedef struct packed {
      logic [REDUCED_BITS-1:0] reduced_width;
      logic [REDUCED_BITS-1:0] reduced_height;
      logic [SCALED_BITS-1:0]  scaled_width;
      logic [SCALED_BITS-1:0]  scaled_height;
      logic                    status;
   } rsp_type;

   // Control from the sequencer to the shared divider.
   typedef struct packed {
      logic start;
      logic long_div;
   } div_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/ard_div.sv
`default_nettype none

// Bit-serial restoring divider. The dividend is side placed above FRAC_BITS
// zero bits. A short run retires DIM_BITS quotient bits, which gives the
// plain quotient side / divisor; a long run retires all DIM_BITS + FRAC_BITS
// bits, which gives the fixed-point quotient. One bit per cycle.
module ard_div #(
   parameter int DIM_BITS  = ard_pkg::DIM_BITS_DEF,
   parameter int FRAC_BITS = ard_pkg::FRAC_BITS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire  ard_pkg::div_ctl_type     ctl,
   input  wire  [DIM_BITS-1:0]            side,
   input  wire  [DIM_BITS-1:0]            divisor,
   output logic                           done,
   output logic [DIM_BITS+FRAC_BITS-1:0]  quotient
);

   localparam int NW = DIM_BITS + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [NW-1:0]       num_ff, num_in;
   logic [NW-1:0]       quo_ff, quo_in;
   logic [DIM_BITS-1:0] rem_ff, rem_in;
   logic [DIM_BITS-1:0] dvs_ff, dvs_in;

   logic [DIM_BITS:0]   trial;
   logic [DIM_BITS:0]   diff;
   logic                fits;

   always_comb begin
      trial = {rem_ff, num_ff[NW-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = ctl.long_div ? CW'(NW) : CW'(DIM_BITS);
         num_in  = {side, {FRAC_BITS{1'b0}}};
         quo_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         quo_in = {quo_ff[NW-2:0], fits};
         rem_in = fits ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: rtl/aspect_ratio_reducer.sv
`default_nettype none

// Reduces a frame size to its aspect ratio. Each request beat carries a width
// and a height, each masked to its low DIM_BITS bits (at most SIDE_BITS); the
// response beat gives both sides divided by their greatest common divisor, and
// both sides divided by the smaller side as unsigned fixed point with FRAC_BITS
// fraction bits, truncated and saturated to 32 bits. A zero side gives status 1
// and all-zero results. Otherwise an item is accepted, runs a binary GCD loop
// on one compare-and-subtract unit, then four runs of one bit-serial divider
// (two short runs of DIM_BITS quotient bits for the reduced sides, two long
// runs of DIM_BITS + FRAC_BITS bits for the scaled sides), and then hands the
// result over. The block takes one item at a time; req_stall is high while an
// item is in work, and a finished response waits in the output register while
// the next request is accepted.
module aspect_ratio_reducer #(
   parameter int DIM_BITS  = ard_pkg::DIM_BITS_DEF,
   parameter int FRAC_BITS = ard_pkg::FRAC_BITS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire ard_pkg::req_type req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output ard_pkg::rsp_type   rsp_data
);

   localparam int DW = (DIM_BITS < ard_pkg::SIDE_BITS) ? DIM_BITS : ard_pkg::SIDE_BITS;
   localparam int NW = DIM_BITS + FRAC_BITS;
   localparam int KW = $clog2(DIM_BITS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GCD  = 3'd1;
   localparam logic [2:0] S_RW   = 3'd2;
   localparam logic [2:0] S_RH   = 3'd3;
   localparam logic [2:0] S_SW   = 3'd4;
   localparam logic [2:0] S_SH   = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic                launched_ff, launched_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ard_pkg::rsp_type    rsp_ff, rsp_in;
   ard_pkg::rsp_type    res_ff, res_in;

   logic [DIM_BITS-1:0] w_ff, w_in;
   logic [DIM_BITS-1:0] h_ff, h_in;
   logic [DIM_BITS-1:0] m_ff, m_in;
   logic [DIM_BITS-1:0] g_ff, g_in;
   logic [DIM_BITS-1:0] a_ff, a_in;
   logic [DIM_BITS-1:0] b_ff, b_in;
   logic [KW-1:0]       k_ff, k_in;

   logic [DIM_BITS-1:0] req_w;
   logic [DIM_BITS-1:0] req_h;
   logic                a_gt_b;
   logic [DIM_BITS-1:0] sub_diff;

   ard_pkg::div_ctl_type div_ctl;
   logic [DIM_BITS-1:0]  div_side;
   logic [DIM_BITS-1:0]  div_divisor;
   logic                 div_done;
   logic [NW-1:0]        div_quo;
   logic [63:0]          quo_wide;
   logic [ard_pkg::SCALED_BITS-1:0] quo_scaled;

   ard_div #(
      .DIM_BITS  (DIM_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .side     (div_side),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      req_w = DIM_BITS'(req_data.width[DW-1:0]);
      req_h = DIM_BITS'(req_data.height[DW-1:0]);

      // One compare and one subtract serve every GCD step.
      a_gt_b   = a_ff > b_ff;
      sub_diff = a_gt_b ? (a_ff - b_ff) : (b_ff - a_ff);

      quo_wide   = 64'(div_quo);
      quo_scaled = (|quo_wide[63:32]) ? '1 : quo_wide[31:0];

      div_side    = ((state_ff == S_RW) || (state_ff == S_SW)) ? w_ff : h_ff;
      div_divisor = ((state_ff == S_RW) || (state_ff == S_RH)) ? g_ff : m_ff;
      div_ctl.long_div = (state_ff == S_SW) || (state_ff == S_SH);
      div_ctl.start    = 1'b0;

      state_in     = state_ff;
      launched_in  = launched_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      res_in       = res_ff;
      w_in = w_ff;
      h_in = h_ff;
      m_in = m_ff;
      g_in = g_ff;
      a_in = a_ff;
      b_in = b_ff;
      k_in = k_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               w_in = req_w;
               h_in = req_h;
               m_in = (req_w < req_h) ? req_w : req_h;
               a_in = req_w;
               b_in = req_h;
               k_in = '0;
               res_in = '0;
               if ((req_w == '0) || (req_h == '0)) begin
                  res_in.status = 1'b1;
                  state_in = S_OUT;
               end else begin
                  state_in = S_GCD;
               end
            end
         end
         S_GCD: begin
            // Binary GCD: strip common factors of two, then odd differences.
            if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + KW'(1);
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff == b_ff) begin
               g_in     = a_ff << k_ff;
               state_in = S_RW;
            end else if (a_gt_b) begin
               a_in = sub_diff >> 1;
            end else begin
               b_in = sub_diff >> 1;
            end
         end
         S_RW, S_RH, S_SW, S_SH: begin
            if (!launched_ff) begin
               div_ctl.start = 1'b1;
               launched_in   = 1'b1;
            end else if (div_done) begin
               launched_in = 1'b0;
               case (state_ff)
                  S_RW: begin
                     res_in.reduced_width = quo_wide[ard_pkg::REDUCED_BITS-1:0];
                     state_in = S_RH;
                  end
                  S_RH: begin
                     res_in.reduced_height = quo_wide[ard_pkg::REDUCED_BITS-1:0];
                     state_in = S_SW;
                  end
                  S_SW: begin
                     res_in.scaled_width = quo_scaled;
                     state_in = S_SH;
                  end
                  default: begin
                     res_in.scaled_height = quo_scaled;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_OUT: begin
            // Hand the result over once the output register is free this cycle.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      res_ff <= res_in;
      w_ff   <= w_in;
      h_ff   <= h_in;
      m_ff   <= m_in;
      g_ff   <= g_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
